@@ rtl/core/fdf_pkg.sv @@
package fdf_pkg;

  localparam int PIX_W    = 8;
  localparam int POS_W    = 5;
  localparam int CFG_W    = 6;
  localparam int CFG_IDX_W = 1;
  localparam int SUM_W    = 10;
  localparam int CNT_W    = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

  // reset values of the frame size registers
  localparam logic [CFG_W-1:0] ROWS_RESET = 6'd20;
  localparam logic [CFG_W-1:0] COLS_RESET = 6'd30;

  // reciprocal of three for the three-neighbor mean
  localparam int RECIP3_SHIFT = 11;
  localparam logic [SUM_W:0] RECIP3 = 11'd683;

  // sequencer to neighbor unit
  typedef struct packed {
    logic center;  // read data is the center pixel
    logic step;    // read data is a neighbor slot
    logic exists;  // that neighbor lies inside the frame
  } fdf_ctl_t;

  // neighbor unit to output register
  typedef struct packed {
    logic [PIX_W-1:0] filtered;
    logic             replaced;
  } fdf_res_t;

endpackage

@@ rtl/core/fdf_ram.sv @@
module fdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/fdf_nbr_unit.sv @@
module fdf_nbr_unit (
  input  logic                      clk,
  input  fdf_pkg::fdf_ctl_t         ctl,
  input  logic [fdf_pkg::PIX_W-1:0] rd_data,
  output fdf_pkg::fdf_res_t         res
);
  import fdf_pkg::*;

  logic [PIX_W-1:0] center_r, center_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic             glitch_r, glitch_nxt;
  logic [PIX_W-1:0] diff;
  logic [SUM_W:0]   sum_p1;
  logic [SUM_W:0]   sum_p2;
  logic [2*SUM_W+1:0] prod3;
  logic [PIX_W-1:0] mean;

  // one compare and accumulate per neighbor
  always_comb begin
    center_nxt = center_r;
    sum_nxt    = sum_r;
    n_nxt      = n_r;
    glitch_nxt = glitch_r;
    diff = (rd_data > center_r) ? (rd_data - center_r) : (center_r - rd_data);
    if (ctl.center) begin
      center_nxt = rd_data;
      sum_nxt    = '0;
      n_nxt      = '0;
      glitch_nxt = 1'b1;
    end else if (ctl.step && ctl.exists && glitch_r) begin
      if (diff <= PIX_W'(1)) begin
        glitch_nxt = 1'b0;
      end else begin
        sum_nxt = sum_r + SUM_W'(rd_data);
        n_nxt   = n_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    center_r <= center_nxt;
    sum_r    <= sum_nxt;
    n_r      <= n_nxt;
    glitch_r <= glitch_nxt;
  end

  // mean rounded half up, floor((2*sum+n)/(2n))
  assign sum_p1 = (SUM_W+1)'(sum_r) + (SUM_W+1)'(1);
  assign sum_p2 = (SUM_W+1)'(sum_r) + (SUM_W+1)'(2);
  assign prod3  = (2*SUM_W+2)'(sum_p1) * (2*SUM_W+2)'(RECIP3);

  always_comb begin
    case (n_r)
      3'd1:    mean = sum_r[PIX_W-1:0];
      3'd2:    mean = sum_p1[PIX_W:1];
      3'd3:    mean = prod3[RECIP3_SHIFT+PIX_W-1:RECIP3_SHIFT];
      3'd4:    mean = sum_p2[PIX_W+1:2];
      default: mean = center_r;
    endcase
  end

  assign res.replaced = glitch_r && (n_r != '0);
  assign res.filtered = res.replaced ? mean : center_r;

endmodule

@@ rtl/core/four_neighbor_deglitch_filter.sv @@
// four-neighbor impulse noise filter over a stored frame
//
// input channel (in_valid / in_stall): one transaction carries op, row, col, pixel.
//   op 0 loads pixel into the frame store and gives no result.
//   op 1 fetches the filtered pixel at row, col and gives one result transaction.
// result channel (out_valid / out_stall): filtered, replaced, status.
// config port: cfg_we writes cfg_wdata to rows (index 0) or columns (index 1);
//   the user writes only while the block is idle; the block does not enforce it.
// a fetch reads the center and four neighbor slots from the single-port frame
//   memory, one read per cycle, through one shared compare/accumulate unit;
//   the input stalls until the fetch has passed the center, neighbor and done
//   states and the sequencer is idle again; a load leaves the sequencer idle,
//   and a fetch outside the frame goes straight to the done state.
// the result sits in an output register; the next item can be taken while it
//   waits, but a later fetch holds in its final step until out_stall drops.
// reset (rst_n low, synchronous) clears the sequencer and the output valid and
//   sets the frame to 20 rows by 30 columns; the frame store itself is not
//   cleared, and every pixel must be loaded before it is fetched.
module four_neighbor_deglitch_filter #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [fdf_pkg::POS_W-1:0]     in_row,
  input  logic [fdf_pkg::POS_W-1:0]     in_col,
  input  logic [fdf_pkg::PIX_W-1:0]     in_pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fdf_pkg::PIX_W-1:0]     out_filtered,
  output logic                          out_replaced,
  output logic                          out_status,
  input  logic                          cfg_we,
  input  logic [fdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fdf_pkg::CFG_W-1:0]     cfg_wdata
);
  import fdf_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W  = 11;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CTR  = 2'd1;
  localparam logic [1:0] ST_NBR  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // neighbor slots, read in this order
  localparam logic [1:0] SLOT_UP    = 2'd0;
  localparam logic [1:0] SLOT_DOWN  = 2'd1;
  localparam logic [1:0] SLOT_LEFT  = 2'd2;
  localparam logic [1:0] SLOT_RIGHT = 2'd3;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [CMP_W-1:0] r,
                                                input logic [CMP_W-1:0] c);
    int lin;
    lin = int'(r) * MAX_COLS + int'(c);
    return lin[ADDR_W-1:0];
  endfunction

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       slot_r, slot_nxt;
  logic [CMP_W-1:0] row_r, row_nxt;
  logic [CMP_W-1:0] col_r, col_nxt;
  logic             oor_r, oor_nxt;
  logic [CFG_W-1:0] rows_r, cols_r;

  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_filtered_r, out_filtered_nxt;
  logic             out_replaced_r, out_replaced_nxt;
  logic             out_status_r, out_status_nxt;

  logic [CMP_W-1:0]  rows_eff, cols_eff;
  logic              pos_ok;
  logic              in_accept;
  logic [3:0]        exists;
  logic [1:0]        rd_slot;
  logic [ADDR_W-1:0] slot_addr;
  logic [ADDR_W-1:0] ram_addr;
  logic              ram_we;
  logic [PIX_W-1:0]  ram_rdata;
  fdf_ctl_t          ctl;
  fdf_res_t          res;
  logic              out_free;

  // effective frame size: register value capped at the store size
  assign rows_eff = (CMP_W'(rows_r) > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS) : CMP_W'(rows_r);
  assign cols_eff = (CMP_W'(cols_r) > CMP_W'(MAX_COLS)) ? CMP_W'(MAX_COLS) : CMP_W'(cols_r);
  assign pos_ok   = (CMP_W'(in_row) < rows_eff) && (CMP_W'(in_col) < cols_eff);

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // which neighbors lie inside the frame
  assign exists[SLOT_UP]    = (row_r != '0);
  assign exists[SLOT_DOWN]  = (row_r + CMP_W'(1)) < rows_eff;
  assign exists[SLOT_LEFT]  = (col_r != '0);
  assign exists[SLOT_RIGHT] = (col_r + CMP_W'(1)) < cols_eff;

  // the slot whose read is issued this cycle
  assign rd_slot = (state_r == ST_CTR) ? SLOT_UP : (slot_r + 2'd1);

  // a missing neighbor re-reads the center; its data is ignored
  always_comb begin
    slot_addr = addr_of(row_r, col_r);
    if (exists[rd_slot]) begin
      case (rd_slot)
        SLOT_UP:    slot_addr = addr_of(row_r - CMP_W'(1), col_r);
        SLOT_DOWN:  slot_addr = addr_of(row_r + CMP_W'(1), col_r);
        SLOT_LEFT:  slot_addr = addr_of(row_r, col_r - CMP_W'(1));
        SLOT_RIGHT: slot_addr = addr_of(row_r, col_r + CMP_W'(1));
        default:    slot_addr = addr_of(row_r, col_r);
      endcase
    end
  end

  assign ram_addr = (state_r == ST_IDLE) ? addr_of(CMP_W'(in_row), CMP_W'(in_col)) : slot_addr;
  assign ram_we   = in_accept && !in_op && pos_ok;

  assign ctl.center = (state_r == ST_CTR);
  assign ctl.step   = (state_r == ST_NBR);
  assign ctl.exists = exists[slot_r];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    oor_nxt   = oor_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && in_op) begin
          row_nxt   = CMP_W'(in_row);
          col_nxt   = CMP_W'(in_col);
          oor_nxt   = !pos_ok;
          state_nxt = pos_ok ? ST_CTR : ST_DONE;
        end
      end
      ST_CTR: begin
        slot_nxt  = SLOT_UP;
        state_nxt = ST_NBR;
      end
      ST_NBR: begin
        if (slot_r == SLOT_RIGHT) begin
          state_nxt = ST_DONE;
        end else begin
          slot_nxt = slot_r + 2'd1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register, loaded at the end of a fetch once the slot is free
  always_comb begin
    out_valid_nxt    = out_valid_r && out_stall;
    out_filtered_nxt = out_filtered_r;
    out_replaced_nxt = out_replaced_r;
    out_status_nxt   = out_status_r;
    if (state_r == ST_DONE && out_free) begin
      out_valid_nxt    = 1'b1;
      out_filtered_nxt = oor_r ? '0 : res.filtered;
      out_replaced_nxt = oor_r ? 1'b0 : res.replaced;
      out_status_nxt   = oor_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rows_r      <= ROWS_RESET;
      cols_r      <= COLS_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == REG_ROWS) begin
        rows_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_COLS) begin
        cols_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    slot_r         <= slot_nxt;
    row_r          <= row_nxt;
    col_r          <= col_nxt;
    oor_r          <= oor_nxt;
    out_filtered_r <= out_filtered_nxt;
    out_replaced_r <= out_replaced_nxt;
    out_status_r   <= out_status_nxt;
  end

  fdf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_pixel),
    .rdata (ram_rdata)
  );

  fdf_nbr_unit u_nbr (
    .clk     (clk),
    .ctl     (ctl),
    .rd_data (ram_rdata),
    .res     (res)
  );

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign out_replaced = out_replaced_r;
  assign out_status   = out_status_r;

endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fdf_pkg::*;

  // input opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 12;
  localparam int FRAME_ROWS     = 32;   // store geometry, matches the default parameters
  localparam int FRAME_COLS     = 32;
  localparam int RANDOM_TXNS    = 550;
  localparam int CALM_AFTER     = 450;  // no idling on either side past this count
  localparam int SETTLE_CYCLES  = 16;   // loads give no result
  localparam int TAIL_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [PIX_W-1:0] filtered;
    logic             replaced;
    logic             status;
  } pixel_result_t;

  localparam pixel_result_t OUT_OF_FRAME = '{filtered: '0, replaced: 1'b0, status: 1'b1};

  // one row of the directed table; want is used only when typed is set
  typedef struct packed {
    logic             op;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [PIX_W-1:0] pixel;
    logic             typed;
    pixel_result_t    want;
  } directed_txn_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_op = 1'b0;
  logic [POS_W-1:0] in_row = '0;
  logic [POS_W-1:0] in_col = '0;
  logic [PIX_W-1:0] in_pixel = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PIX_W-1:0] out_filtered;
  logic             out_replaced;
  logic             out_status;
  logic             cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // shadow copy of the frame store and the frame size registers
  logic [PIX_W-1:0] shadow_px [FRAME_ROWS*FRAME_COLS];
  bit               shadow_loaded [FRAME_ROWS*FRAME_COLS];
  logic [CFG_W-1:0] rows_cfg = ROWS_RESET;
  logic [CFG_W-1:0] cols_cfg = COLS_RESET;

  pixel_result_t results_due [$];   // filtered pixels still owed by the block

  directed_txn_t directed_plan [23];
  int pct_levels [3] = '{0, 15, 40};
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned stall_pct = 0;
  int unsigned gap_pct = 0;
  int unsigned txn_count = 0;

  four_neighbor_deglitch_filter dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_pixel     (in_pixel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_filtered (out_filtered),
    .out_replaced (out_replaced),
    .out_status   (out_status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  // effective frame size: registers above the store geometry saturate
  function automatic int rows_eff();
    return (int'(rows_cfg) > FRAME_ROWS) ? FRAME_ROWS : int'(rows_cfg);
  endfunction

  function automatic int cols_eff();
    return (int'(cols_cfg) > FRAME_COLS) ? FRAME_COLS : int'(cols_cfg);
  endfunction

  function automatic bit in_frame(int r, int c);
    return (r < rows_eff()) && (c < cols_eff());
  endfunction

  // neighbor k (up, down, left, right) of r, c and whether it lies inside the frame
  function automatic bit neighbor_at(int r, int c, int k, output int nr, output int nc);
    nr = r;
    nc = c;
    case (k)
      0: nr = r - 1;
      1: nr = r + 1;
      2: nc = c - 1;
      default: nc = c + 1;
    endcase
    return (nr >= 0) && (nc >= 0) && in_frame(nr, nc);
  endfunction

  // filtered value of the stored pixel at r, c
  function automatic pixel_result_t filter_pixel_at(int r, int c);
    pixel_result_t res;
    int center, nb, nr, nc, total, count, diff;
    bit all_far;
    res = OUT_OF_FRAME;
    if (!in_frame(r, c)) return res;
    center = int'(shadow_px[r*FRAME_COLS + c]);
    total = 0;
    count = 0;
    all_far = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (neighbor_at(r, c, k, nr, nc)) begin
        nb = int'(shadow_px[nr*FRAME_COLS + nc]);
        diff = (nb > center) ? nb - center : center - nb;
        // one close neighbor is enough to keep the pixel
        if (diff <= 1) all_far = 1'b0;
        total += nb;
        count++;
      end
    end
    res.status = 1'b0;
    res.replaced = 1'b0;
    res.filtered = center[PIX_W-1:0];
    // glitch: neighbor mean rounded half up; a lone pixel has no neighbors and stays
    if (all_far && count > 0) begin
      res.filtered = PIX_W'((2*total + count) / (2*count));
      res.replaced = 1'b1;
    end
    return res;
  endfunction

  // a fetch inside the frame may only touch pixels that were loaded
  function automatic bit safe_to_fetch(int r, int c);
    int nr, nc;
    if (!in_frame(r, c)) return 1'b1;
    if (!shadow_loaded[r*FRAME_COLS + c]) return 1'b0;
    for (int k = 0; k < 4; k++)
      if (neighbor_at(r, c, k, nr, nc) && !shadow_loaded[nr*FRAME_COLS + nc]) return 1'b0;
    return 1'b1;
  endfunction

  // mostly a smooth background near base, with spikes, extremes and noise
  function automatic logic [PIX_W-1:0] pick_pixel(int base);
    int v, k;
    k = int'($urandom_range(99));
    if (k < 45) begin
      v = base + int'($urandom_range(2)) - 1;
    end else if (k < 65) begin
      v = $urandom_range(1) ? base + int'($urandom_range(4, 2))
                            : base - int'($urandom_range(4, 2));
    end else if (k < 80) begin
      v = $urandom_range(1) ? 255 : 0;
    end else begin
      v = int'($urandom_range(255));
    end
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[PIX_W-1:0];
  endfunction

  // drive one transaction and hold it until accepted, then update the shadow state
  task automatic send_txn(logic op, int r, int c, logic [PIX_W-1:0] px,
                          bit typed, pixel_result_t want);
    in_valid <= 1'b1;
    in_op    <= op;
    in_row   <= r[POS_W-1:0];
    in_col   <= c[POS_W-1:0];
    in_pixel <= px;
    do @(posedge clk); while (in_stall);
    if (op == OP_FETCH) begin
      results_due.push_back(typed ? want : filter_pixel_at(r, c));
      txn_count++;
    end else if (in_frame(r, c)) begin
      // loads outside the frame are dropped by the block
      shadow_px[r*FRAME_COLS + c] = px;
      shadow_loaded[r*FRAME_COLS + c] = 1'b1;
      txn_count++;
    end
  endtask

  // random sender gap, taken with gap_pct percent chance
  task automatic maybe_gap();
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
  endtask

  // stop sending until every owed result came back, then let the block settle
  task automatic wait_results_in(int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_frame_size(logic [CFG_W-1:0] rows_val, logic [CFG_W-1:0] cols_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_wdata <= rows_val;
    @(posedge clk);
    cfg_index <= REG_COLS;
    cfg_wdata <= cols_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    rows_cfg = rows_val;
    cols_cfg = cols_val;
  endtask

  task automatic log_mismatch(string what, pixel_result_t want, pixel_result_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: expected %0d/%0b/%0b, got %0d/%0b/%0b (filtered/replaced/status)",
               $time, what, want.filtered, want.replaced, want.status,
               got.filtered, got.replaced, got.status);
  endtask

  // result side back-pressure in bursts, with out_stall low between bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (!out_stall && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(5, 1);
    end
    out_stall <= (stall_left != 0);
  end

  // result checker and activity counter for the watchdog
  always @(posedge clk) begin
    pixel_result_t got, want;
    got = '{out_filtered, out_replaced, out_status};
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (results_due.size() == 0) begin
        log_mismatch("result with nothing owed", '0, got);
      end else begin
        want = results_due.pop_front();
        if (got !== want) log_mismatch("result mismatch", want, got);
      end
    end
  end

  // watchdog: too long without any transaction on either channel
  initial begin
    do @(posedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
    $display("[four_neighbor_deglitch_filter] ERROR");
    $finish;
  end

  initial begin
    int phase, nr, nc, wr, wc, r0, c0, base, n_items, kind, r, c, tries;
    bit calm;
    logic op;
    logic [CFG_W-1:0] rows_val, cols_val;

    // directed part, run on the reset frame of 20 rows by 30 columns
    directed_plan = '{
      '{OP_FETCH, 5'd20, 5'd0,  8'd0,   1'b1, OUT_OF_FRAME},      // first row past the frame
      '{OP_FETCH, 5'd0,  5'd30, 8'd0,   1'b1, OUT_OF_FRAME},      // first column past the frame
      '{OP_FETCH, 5'd31, 5'd31, 8'd0,   1'b1, OUT_OF_FRAME},      // far corner of the store
      '{OP_LOAD,  5'd31, 5'd31, 8'd255, 1'b0, '0},                // load outside, dropped
      // top left corner spike with two dark neighbors
      '{OP_LOAD,  5'd0,  5'd0,  8'd255, 1'b0, '0},
      '{OP_LOAD,  5'd0,  5'd1,  8'd0,   1'b0, '0},
      '{OP_LOAD,  5'd1,  5'd0,  8'd0,   1'b0, '0},
      '{OP_FETCH, 5'd0,  5'd0,  8'd0,   1'b1, '{8'd0, 1'b1, 1'b0}},
      // dark pixel on the top border among three full-scale neighbors
      '{OP_LOAD,  5'd0,  5'd10, 8'd0,   1'b0, '0},
      '{OP_LOAD,  5'd1,  5'd10, 8'd255, 1'b0, '0},
      '{OP_LOAD,  5'd0,  5'd9,  8'd255, 1'b0, '0},
      '{OP_LOAD,  5'd0,  5'd11, 8'd255, 1'b0, '0},
      '{OP_FETCH, 5'd0,  5'd10, 8'd0,   1'b1, '{8'd255, 1'b1, 1'b0}},
      // bottom right corner, one neighbor within 1 keeps the pixel
      '{OP_LOAD,  5'd19, 5'd29, 8'd100, 1'b0, '0},
      '{OP_LOAD,  5'd18, 5'd29, 8'd101, 1'b0, '0},
      '{OP_LOAD,  5'd19, 5'd28, 8'd50,  1'b0, '0},
      '{OP_FETCH, 5'd19, 5'd29, 8'd0,   1'b1, '{8'd100, 1'b0, 1'b0}},
      // interior spike whose neighbor mean lands on one half
      '{OP_LOAD,  5'd5,  5'd5,  8'd200, 1'b0, '0},
      '{OP_LOAD,  5'd4,  5'd5,  8'd10,  1'b0, '0},
      '{OP_LOAD,  5'd6,  5'd5,  8'd11,  1'b0, '0},
      '{OP_LOAD,  5'd5,  5'd4,  8'd10,  1'b0, '0},
      '{OP_LOAD,  5'd5,  5'd6,  8'd11,  1'b0, '0},
      '{OP_FETCH, 5'd5,  5'd5,  8'd0,   1'b0, '0}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    gap_pct = 30;
    stall_pct = 30;
    foreach (directed_plan[i]) begin
      maybe_gap();
      send_txn(directed_plan[i].op, int'(directed_plan[i].row), int'(directed_plan[i].col),
               directed_plan[i].pixel, directed_plan[i].typed, directed_plan[i].want);
    end

    // random part: phases of one frame size each, a loaded window, then mixed traffic
    txn_count = 0;
    for (phase = 0; txn_count < RANDOM_TXNS; phase++) begin
      case (phase)
        0: begin rows_val = 6'd1;  cols_val = 6'd1;  end   // single-pixel frame
        1: begin rows_val = 6'd0;  cols_val = 6'd5;  end   // no rows at all
        2: begin rows_val = 6'd63; cols_val = 6'd1;  end   // rows saturate at the store size
        3: begin rows_val = 6'd1;  cols_val = 6'd40; end   // columns saturate
        4: begin rows_val = 6'd32; cols_val = 6'd32; end   // full store
        5: begin rows_val = 6'd7;  cols_val = 6'd0;  end   // no columns at all
        default: begin
          kind = int'($urandom_range(99));
          if (kind < 70) begin
            rows_val = CFG_W'($urandom_range(8, 1));
            cols_val = CFG_W'($urandom_range(8, 1));
          end else if (kind < 85) begin
            rows_val = CFG_W'($urandom_range(63, 9));
            cols_val = CFG_W'($urandom_range(8, 1));
          end else begin
            rows_val = CFG_W'($urandom_range(8, 1));
            cols_val = CFG_W'($urandom_range(63, 9));
          end
        end
      endcase

      // pick the idling for this phase first, so stall bursts die out while settling
      calm = (txn_count >= CALM_AFTER);
      gap_pct = calm ? 0 : pct_levels[$urandom_range(2)];
      stall_pct = calm ? 0 : pct_levels[$urandom_range(2)];

      // the size registers are only written with the block idle
      wait_results_in(SETTLE_CYCLES);
      write_frame_size(rows_val, cols_val);

      nr = rows_eff();
      nc = cols_eff();
      base = int'($urandom_range(255));

      if (nr == 0 || nc == 0) begin
        // nothing lies inside: every fetch is flagged and every load dropped
        repeat (12) begin
          maybe_gap();
          send_txn(1'($urandom_range(1)), int'($urandom_range(31)), int'($urandom_range(31)),
                   pick_pixel(base), 1'b0, '0);
        end
      end else begin
        // window of at most 6 by 6 pixels, so large frames stay cheap to fill
        wr = int'($urandom_range(6, 1));
        wc = int'($urandom_range(6, 1));
        if (wr > nr) wr = nr;
        if (wc > nc) wc = nc;
        r0 = int'($urandom_range(nr - wr));
        c0 = int'($urandom_range(nc - wc));
        for (r = r0; r < r0 + wr; r++) begin
          for (c = c0; c < c0 + wc; c++) begin
            maybe_gap();
            send_txn(OP_LOAD, r, c, pick_pixel(base), 1'b0, '0);
          end
        end

        n_items = int'($urandom_range(40, 20));
        for (int i = 0; i < n_items; i++) begin
          maybe_gap();
          // now and then the sender holds off until the result side is empty
          if (phase % 4 == 3 && i == n_items / 2) wait_results_in(0);
          kind = int'($urandom_range(99));
          op = OP_LOAD;
          r = r0 + int'($urandom_range(wr - 1));
          c = c0 + int'($urandom_range(wc - 1));
          if (kind < 55) begin
            // fetch in the window, retrying positions that still touch unloaded pixels
            for (tries = 0; tries < 4 && !safe_to_fetch(r, c); tries++) begin
              r = r0 + int'($urandom_range(wr - 1));
              c = c0 + int'($urandom_range(wc - 1));
            end
            op = safe_to_fetch(r, c) ? OP_FETCH : OP_LOAD;
          end else if (kind < 75) begin
            // reload around the window, one pixel past its border
            r = r0 - 1 + int'($urandom_range(wr + 1));
            c = c0 - 1 + int'($urandom_range(wc + 1));
            if (r < 0) r = 0;
            if (c < 0) c = 0;
            if (r >= nr) r = nr - 1;
            if (c >= nc) c = nc - 1;
          end else if (kind < 92 && (nr < FRAME_ROWS || nc < FRAME_COLS)) begin
            // position past the frame, as flagged fetch or dropped load
            op = (kind < 85) ? OP_FETCH : OP_LOAD;
            if (nr < FRAME_ROWS && (nc == FRAME_COLS || $urandom_range(1))) begin
              r = int'($urandom_range(31, nr));
              c = int'($urandom_range(31));
            end else begin
              r = int'($urandom_range(31));
              c = int'($urandom_range(31, nc));
            end
          end else if (kind >= 92) begin
            // noise anywhere in the address range
            r = int'($urandom_range(31));
            c = int'($urandom_range(31));
            op = ($urandom_range(1) && safe_to_fetch(r, c)) ? OP_FETCH : OP_LOAD;
          end
          send_txn(op, r, c, pick_pixel(base), 1'b0, '0);
        end
      end
    end

    // drain, then give the block time to show any stray result
    wait_results_in(TAIL_CYCLES);
    if (results_due.size() != 0) fail_count++;

    if (fail_count == 0) begin
      $display("[four_neighbor_deglitch_filter] OK");
    end else begin
      $display("[four_neighbor_deglitch_filter] ERROR");
    end
    $finish;
  end

endmodule
